[rtl/eqhz_pkg.sv]
package eqhz_pkg;

   localparam int AngBits = 32;
   localparam int CordicStages = 30;
   localparam int WideBits = 36;
   localparam logic signed [WideBits-1:0] QOne = 36'sd1073741824;
   localparam logic signed [WideBits-1:0] CordicGain = 36'sd652032874;
   localparam logic [AngBits-1:0] AngQuarter = 32'h4000_0000;
   localparam logic [AngBits-1:0] AngHalf = 32'h8000_0000;
   localparam logic [AngBits-1:0] AngThreeQuarter = 32'hC000_0000;

   localparam logic [1:0] RegLatitude = 2'd0;
   localparam logic [1:0] RegThreshold = 2'd1;

   localparam int QuoBits = 32;

   // atan(2^-i) in binary angle units with a full turn of 2^32.
   function automatic logic signed [AngBits:0] atan_step(input int i);
      logic signed [AngBits:0] r;
      unique case (i)
         0: r = 33'sd536870912;
         1: r = 33'sd316933406;
         2: r = 33'sd167458907;
         3: r = 33'sd85004756;
         4: r = 33'sd42667331;
         5: r = 33'sd21354465;
         6: r = 33'sd10679838;
         7: r = 33'sd5340245;
         8: r = 33'sd2670163;
         9: r = 33'sd1335087;
         10: r = 33'sd667544;
         11: r = 33'sd333772;
         12: r = 33'sd166886;
         13: r = 33'sd83443;
         14: r = 33'sd41722;
         15: r = 33'sd20861;
         16: r = 33'sd10430;
         17: r = 33'sd5215;
         18: r = 33'sd2608;
         19: r = 33'sd1304;
         20: r = 33'sd652;
         21: r = 33'sd326;
         22: r = 33'sd163;
         23: r = 33'sd81;
         24: r = 33'sd41;
         25: r = 33'sd20;
         26: r = 33'sd10;
         27: r = 33'sd5;
         28: r = 33'sd3;
         29: r = 33'sd1;
         default: r = '0;
      endcase
      return r;
   endfunction

   // Q6.30 product, rounded half up.
   function automatic logic signed [WideBits-1:0] mulq(input logic signed [WideBits-1:0] a,
                                                        input logic signed [WideBits-1:0] b);
      logic signed [2*WideBits-1:0] p;
      p = a * b + (72'sd1 <<< 29);
      return WideBits'(p >>> 30);
   endfunction

   function automatic logic signed [WideBits-1:0] clamp_one(input logic signed [WideBits+1:0] v);
      logic signed [WideBits-1:0] r;
      if (v > 38'sd1073741824) begin
         r = QOne;
      end else if (v < -38'sd1073741824) begin
         r = -QOne;
      end else begin
         r = WideBits'(v);
      end
      return r;
   endfunction

endpackage

[rtl/equatorial_to_horizontal_top.sv]
// Depth: 190 pipeline stages plus the output register.
// Throughput: one item per cycle while the skid entry is empty; each CORDIC iteration,
// each square root bit and each quotient bit is its own register stage, and a stall
// freezes the whole pipeline.
// A two-entry skid buffer at the output parts the result side from the pipeline.
// Reset is synchronous and active high; it clears valid bits and sets latitude to 0 and
// the near-zero threshold to 1.
module equatorial_to_horizontal_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // hour_angle[31:0], declination[63:32]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // altitude[31:0], azimuth[63:32], pole_case[64],
                                    // edge_case[65], zero fill [71:66]
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int W = eqhz_pkg::WideBits;
   localparam int N = eqhz_pkg::CordicStages;
   localparam int A = eqhz_pkg::AngBits;
   localparam int RootSteps = 31;   // bit pairs of a 62-bit radicand
   localparam int QB = eqhz_pkg::QuoBits;

   typedef logic signed [W-1:0] q_type;
   typedef logic signed [A:0] ang_type;

   // ---------------- configuration ----------------
   logic [31:0] lat_ff;
   logic [15:0] thr_ff;
   logic        wr_en;
   logic [1:0]  reg_idx;

   assign csr_pready = 1'b1;
   assign reg_idx = 2'(csr_paddr[2]);
   assign wr_en = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         lat_ff <= '0;
         thr_ff <= 16'd1;
      end else if (wr_en && csr_paddr[1:0] == 2'b00) begin
         if (reg_idx == eqhz_pkg::RegLatitude) lat_ff <= csr_pwdata;
         if (reg_idx == eqhz_pkg::RegThreshold) thr_ff <= csr_pwdata[15:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[1:0] == 2'b00) begin
         unique case (reg_idx)
            eqhz_pkg::RegLatitude: csr_prdata = lat_ff;
            eqhz_pkg::RegThreshold: csr_prdata = {16'd0, thr_ff};
            default: csr_prdata = '0;
         endcase
      end
   end

   // ---------------- pipeline control ----------------
   logic adv;   // whole pipeline moves
   logic skid_full_ff, out_valid_ff;

   // ---------------- stage descriptions ----------------
   // Phase A: three sin/cos CORDICs in parallel (N stages).
   // Phase B: products (3 stages).
   // Phase C: cos_alt square root (RootSteps + 1 stages).
   // Phase D: altitude atan2 (N stages) alongside numerator/denominator (2 stages).
   // Phase E: quotient divider.
   // Phase F: co_root of quotient (RootSteps + 1 stages).
   // Phase G: azimuth atan2 (N stages), then output.
   // From Phase B on, side information other than the overflow flag rides in one struct.

   typedef struct packed {
      logic [31:0] ha;
      q_type sin_lat, cos_lat, sin_dec, cos_dec, sin_ha, cos_ha;
      q_type sin_alt, cos_alt;
      logic [31:0] alt;
      logic  pole, edge_c;
      q_type num, den;
      q_type q;
   } side_type;

   // --- Phase A: sin/cos ---
   typedef struct packed {
      q_type x, y;
      ang_type z;
      logic neg;
   } sc_type;

   function automatic sc_type sc_init(input logic [A-1:0] ang);
      sc_type r;
      logic [A-1:0] a;
      a = ang;
      r.neg = 1'b0;
      if (a >= eqhz_pkg::AngQuarter && a < eqhz_pkg::AngThreeQuarter) begin
         a = a - eqhz_pkg::AngHalf;
         r.neg = 1'b1;
      end
      r.x = eqhz_pkg::CordicGain;
      r.y = '0;
      r.z = ang_type'($signed(a));
      return r;
   endfunction

   function automatic sc_type sc_step(input sc_type s, input int i);
      sc_type r;
      q_type dx, dy;
      r = s;
      dx = s.y >>> i;
      dy = s.x >>> i;
      if (!s.z[A]) begin
         r.x = s.x - dx; r.y = s.y + dy; r.z = s.z - eqhz_pkg::atan_step(i);
      end else begin
         r.x = s.x + dx; r.y = s.y - dy; r.z = s.z + eqhz_pkg::atan_step(i);
      end
      return r;
   endfunction

   // atan2 CORDIC
   typedef struct packed {
      q_type x, y;
      ang_type z;
   } at_type;

   function automatic at_type at_init(input q_type y, input q_type x);
      at_type r;
      r.x = x; r.y = y; r.z = '0;
      if (x < 0) begin
         if (y >= 0) begin
            r.y = -x; r.x = y; r.z = ang_type'(eqhz_pkg::AngQuarter);
         end else begin
            r.y = x; r.x = -y; r.z = -ang_type'(eqhz_pkg::AngQuarter);
         end
      end
      return r;
   endfunction

   function automatic at_type at_step(input at_type s, input int i);
      at_type r;
      q_type dx, dy;
      dx = s.y >>> i;
      dy = s.x >>> i;
      if (s.y >= 0) begin
         r.x = s.x + dx; r.y = s.y - dy; r.z = s.z + eqhz_pkg::atan_step(i);
      end else begin
         r.x = s.x - dx; r.y = s.y + dy; r.z = s.z - eqhz_pkg::atan_step(i);
      end
      return r;
   endfunction

   // Square root: one result bit per stage on a 62-bit radicand.
   typedef struct packed {
      logic [61:0] v;
      logic [61:0] r;
   } rt_type;

   function automatic rt_type rt_init(input q_type s);
      rt_type o;
      logic signed [2*W-1:0] sq;
      logic [63:0] one;
      sq = s * s;
      one = 64'd1 << 60;
      o.v = (64'(sq) >= one) ? '0 : 62'(one - 64'(sq));
      o.r = '0;
      return o;
   endfunction

   function automatic rt_type rt_step(input rt_type s, input int k);
      rt_type o;
      logic [61:0] bit_v;
      bit_v = 62'd1 << (2 * (RootSteps - 1 - k));
      o = s;
      if (s.v >= s.r + bit_v) begin
         o.v = s.v - (s.r + bit_v);
         o.r = (s.r >> 1) + bit_v;
      end else begin
         o.r = s.r >> 1;
      end
      return o;
   endfunction

   // Quotient (num * 2^30) / den, truncating toward zero, restoring division.
   typedef struct packed {
      logic [62:0] rem;   // partial dividend magnitude
      logic [31:0] dvs;   // divisor magnitude
      logic [QB-1:0] quo;
      logic neg;
   } dv_type;

   function automatic dv_type dv_step(input dv_type s, input int k);
      dv_type o;
      logic [62:0] trial;
      o = s;
      trial = 63'(s.dvs) << (QB - 1 - k);
      if (s.rem >= trial) begin
         o.rem = s.rem - trial;
         o.quo[QB-1-k] = 1'b1;
      end
      return o;
   endfunction

   // total stage layout
   localparam int PA = N;
   localparam int PB = 3;
   localparam int PC = RootSteps + 1;
   localparam int PD = N;
   localparam int PE = QB + 1;
   localparam int PF = RootSteps + 1;
   localparam int PG = N;
   localparam int Depth = PA + PB + PC + PD + PE + PF + PG;

   logic [Depth-1:0] vld_ff;

   // Phase A registers
   sc_type sa_lat_ff [PA], sa_dec_ff [PA], sa_ha_ff [PA];
   logic [31:0] sa_ha_raw_ff [PA];

   always_ff @(posedge clock) begin
      if (adv) begin
         sa_lat_ff[0] <= sc_step(sc_init(lat_ff), 0);
         sa_dec_ff[0] <= sc_step(sc_init(req_tdata[63:32]), 0);
         sa_ha_ff[0] <= sc_step(sc_init(req_tdata[31:0]), 0);
         sa_ha_raw_ff[0] <= req_tdata[31:0];
         for (int i = 1; i < PA; i++) begin
            sa_lat_ff[i] <= sc_step(sa_lat_ff[i-1], i);
            sa_dec_ff[i] <= sc_step(sa_dec_ff[i-1], i);
            sa_ha_ff[i] <= sc_step(sa_ha_ff[i-1], i);
            sa_ha_raw_ff[i] <= sa_ha_raw_ff[i-1];
         end
      end
   end

   // Phase B: products
   side_type sb_ff [PB];
   side_type sb0_in;
   q_type lat_ll;
   q_type cdh_in;
   logic signed [W+1:0] sum_in;

   always_comb begin
      sb0_in = '0;
      sb0_in.ha = sa_ha_raw_ff[PA-1];
      sb0_in.sin_lat = sa_lat_ff[PA-1].neg ? -sa_lat_ff[PA-1].y : sa_lat_ff[PA-1].y;
      sb0_in.cos_lat = sa_lat_ff[PA-1].neg ? -sa_lat_ff[PA-1].x : sa_lat_ff[PA-1].x;
      sb0_in.sin_dec = sa_dec_ff[PA-1].neg ? -sa_dec_ff[PA-1].y : sa_dec_ff[PA-1].y;
      sb0_in.cos_dec = sa_dec_ff[PA-1].neg ? -sa_dec_ff[PA-1].x : sa_dec_ff[PA-1].x;
      sb0_in.sin_ha = sa_ha_ff[PA-1].neg ? -sa_ha_ff[PA-1].y : sa_ha_ff[PA-1].y;
      sb0_in.cos_ha = sa_ha_ff[PA-1].neg ? -sa_ha_ff[PA-1].x : sa_ha_ff[PA-1].x;
   end

   // Stage B0: latch trig; B0->B1: cos_lat*cos_dec into num, sin_lat*sin_dec into den,
   // and cosDec*cosHA into q for the edge test; B1->B2: sum into sin_alt, pole and edge flags.
   side_type sb1_in, sb2_in;
   logic [W-1:0] abs_cl;
   logic signed [W-1:0] edge_p;
   always_comb begin
      sb1_in = sb_ff[0];
      sb1_in.num = eqhz_pkg::mulq(sb_ff[0].cos_lat, sb_ff[0].cos_dec);
      sb1_in.den = eqhz_pkg::mulq(sb_ff[0].sin_lat, sb_ff[0].sin_dec);
      sb1_in.q = eqhz_pkg::mulq(sb_ff[0].cos_dec, sb_ff[0].cos_ha);
      sb2_in = sb_ff[1];
      cdh_in = eqhz_pkg::mulq(sb_ff[1].num, sb_ff[1].cos_ha);
      sum_in = (W+2)'(sb_ff[1].den) + (W+2)'(cdh_in);
      sb2_in.sin_alt = eqhz_pkg::clamp_one(sum_in);
      edge_p = eqhz_pkg::mulq(sb_ff[1].q, sb_ff[1].cos_lat);
      abs_cl = sb_ff[1].cos_lat[W-1] ? W'(-sb_ff[1].cos_lat) : W'(sb_ff[1].cos_lat);
      lat_ll = edge_p[W-1] ? -edge_p : edge_p;
      sb2_in.pole = abs_cl <= W'(thr_ff);
      sb2_in.edge_c = !sb2_in.pole && (W'(lat_ll) <= W'(thr_ff));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sb_ff[0] <= sb0_in;
         sb_ff[1] <= sb1_in;
         sb_ff[2] <= sb2_in;
      end
   end

   // Phase C: cos_alt = co_root(sin_alt); the radicand is set up in its own stage.
   rt_type rc_ff [PC];
   side_type sc_ff [PC];
   always_ff @(posedge clock) begin
      if (adv) begin
         rc_ff[0] <= rt_init(sb_ff[2].sin_alt);
         sc_ff[0] <= sb_ff[2];
         for (int k = 1; k < PC; k++) begin
            rc_ff[k] <= rt_step(rc_ff[k-1], k - 1);
            sc_ff[k] <= sc_ff[k-1];
         end
      end
   end

   // Phase D: altitude atan2 with numerator and denominator alongside
   at_type ad_ff [PD];
   side_type sd_ff [PD];
   side_type sd0_in, sd1_in;
   always_comb begin
      sd0_in = sc_ff[PC-1];
      sd0_in.cos_alt = q_type'({1'b0, rc_ff[PC-1].r[W-2:0]});
      sd0_in.num = eqhz_pkg::mulq(sd0_in.sin_alt, sd0_in.sin_lat);
      sd0_in.den = eqhz_pkg::mulq(sd0_in.cos_lat, sd0_in.cos_alt);
      sd1_in = sd_ff[0];
      sd1_in.num = sd_ff[0].sin_dec - sd_ff[0].num;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         ad_ff[0] <= at_step(at_init(sd0_in.sin_alt, sd0_in.cos_alt), 0);
         sd_ff[0] <= sd0_in;
         ad_ff[1] <= at_step(ad_ff[0], 1);
         sd_ff[1] <= sd1_in;
         for (int i = 2; i < PD; i++) begin
            ad_ff[i] <= at_step(ad_ff[i-1], i);
            sd_ff[i] <= sd_ff[i-1];
         end
      end
   end

   // Phase E: divider. Stage 0 sets up, then one quotient bit per stage.
   dv_type de_ff [PE];
   side_type se_ff [PE];
   side_type se0_in;
   dv_type de0_in;
   logic [W-1:0] an, ad;
   always_comb begin
      se0_in = sd_ff[PD-1];
      se0_in.alt = ad_ff[PD-1].z[A-1:0];
      an = se0_in.num[W-1] ? W'(-se0_in.num) : W'(se0_in.num);
      ad = se0_in.den[W-1] ? W'(-se0_in.den) : W'(se0_in.den);
      de0_in.rem = 63'(an) << 30;
      de0_in.dvs = 32'(ad);
      de0_in.quo = '0;
      de0_in.neg = se0_in.num[W-1] ^ se0_in.den[W-1];
   end

   // A magnitude quotient that would exceed QB bits is clamped to one later anyway:
   // the first divider stage's overflow test, which also catches a zero divisor, flags it.
   logic ovf_in;
   assign ovf_in = (de_ff[0].dvs == '0) ||
                   (de_ff[0].rem >= (63'(de_ff[0].dvs) << QB));

   logic ovf_ff [PE];
   always_ff @(posedge clock) begin
      if (adv) begin
         de_ff[0] <= de0_in;
         se_ff[0] <= se0_in;
         ovf_ff[0] <= 1'b0;
         de_ff[1] <= dv_step(de_ff[0], 0);
         se_ff[1] <= se_ff[0];
         ovf_ff[1] <= ovf_in;
         for (int k = 2; k < PE; k++) begin
            de_ff[k] <= dv_step(de_ff[k-1], k - 1);
            se_ff[k] <= se_ff[k-1];
            ovf_ff[k] <= ovf_ff[k-1];
         end
      end
   end

   // Phase F: co_root of the quotient
   side_type sf0_in;
   q_type qmag;
   always_comb begin
      sf0_in = se_ff[PE-1];
      if (ovf_ff[PE-1] || de_ff[PE-1].quo > QB'(eqhz_pkg::QOne)) begin
         qmag = eqhz_pkg::QOne;
      end else begin
         qmag = q_type'({4'd0, de_ff[PE-1].quo});
      end
      if (se_ff[PE-1].den == '0) begin
         sf0_in.q = se_ff[PE-1].num > 0 ? eqhz_pkg::QOne :
                    (se_ff[PE-1].num < 0 ? -eqhz_pkg::QOne : '0);
      end else begin
         sf0_in.q = de_ff[PE-1].neg ? -qmag : qmag;
      end
   end

   rt_type rf_ff [PF];
   side_type sf_ff [PF];
   always_ff @(posedge clock) begin
      if (adv) begin
         rf_ff[0] <= rt_init(sf0_in.q);
         sf_ff[0] <= sf0_in;
         for (int k = 1; k < PF; k++) begin
            rf_ff[k] <= rt_step(rf_ff[k-1], k - 1);
            sf_ff[k] <= sf_ff[k-1];
         end
      end
   end

   // Phase G: azimuth atan2
   at_type ag_ff [PG];
   side_type sg_ff [PG];
   always_ff @(posedge clock) begin
      if (adv) begin
         ag_ff[0] <= at_step(at_init(q_type'({1'b0, rf_ff[PF-1].r[W-2:0]}),
                                     sf_ff[PF-1].q), 0);
         sg_ff[0] <= sf_ff[PF-1];
         for (int i = 1; i < PG; i++) begin
            ag_ff[i] <= at_step(ag_ff[i-1], i);
            sg_ff[i] <= sg_ff[i-1];
         end
      end
   end

   // result assembly
   logic [65:0] res_in;
   logic [31:0] az_in;
   side_type sl;
   always_comb begin
      sl = sg_ff[PG-1];
      if (sl.pole) begin
         az_in = sl.ha;
      end else if (sl.edge_c) begin
         az_in = sl.sin_ha >= 0 ? eqhz_pkg::AngQuarter : eqhz_pkg::AngThreeQuarter;
      end else if (sl.sin_ha > 0) begin
         az_in = -ag_ff[PG-1].z[A-1:0];
      end else begin
         az_in = ag_ff[PG-1].z[A-1:0];
      end
      res_in = {sl.edge_c, sl.pole, az_in, sl.alt};
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[Depth-2:0], req_tvalid};
      end
   end

   // output register plus skid entry
   logic [65:0] out_ff, skid_ff;
   logic        pipe_out;
   assign pipe_out = vld_ff[Depth-1];
   assign adv = !skid_full_ff;
   assign req_tready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_full_ff <= 1'b0;
      end else begin
         if (!out_valid_ff || rsp_tready) begin
            if (skid_full_ff) begin
               out_valid_ff <= 1'b1;
               skid_full_ff <= 1'b0;
            end else begin
               out_valid_ff <= adv && pipe_out;
            end
         end else if (adv && pipe_out) begin
            skid_full_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || rsp_tready) begin
         out_ff <= skid_full_ff ? skid_ff : res_in;
      end
      if (out_valid_ff && !rsp_tready && !skid_full_ff) begin
         skid_ff <= res_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = {6'd0, out_ff};

`ifndef SYNTHESIS
   // The skid entry only fills while the output register is held.
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_full_ff |-> out_valid_ff)
      else $error("skid entry full without a held result");
   // A held result with a full skid freezes the pipeline.
   a_freeze: assert property (@(posedge clock) disable iff (reset)
      skid_full_ff |-> !req_tready)
      else $error("pipeline advanced with a full skid entry");
   // Pole and edge flags never appear together.
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[64] && rsp_tdata[65]))
      else $error("pole and edge flags both set");
`endif

endmodule

[tb/testbench.sv]
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [31:0] altitude;
      logic [31:0] azimuth;
      logic        pole_hit;
      logic        edge_hit;
   } horizon_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [71:0] rsp_tdata;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   equatorial_to_horizontal_top u_top (.*);

   longint   rot_angle [0:eqhz_pkg::CordicStages-1];
   logic [31:0] site_lat;
   logic [15:0] near_zero_thr;
   horizon_type expected_pos[$];
   int       errors;
   int       stall_left;
   int       hold_request;
   bit       sender_jitter;
   bit       ready_jitter;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   task automatic report(input string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      errors++;
   endtask

   // ---------------------------------------------------------------- predictor

   function automatic longint unsigned high_product(input longint unsigned a,
                                                    input longint unsigned b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[127:64];
   endfunction

   // atan(2^-i) as a binary angle, from the arctangent series in 64-bit turns.
   function automatic longint arctan_step(input int i);
      longint unsigned p, sum, turns;
      int unsigned k;
      if (i == 0) begin
         return 64'sd536870912;
      end
      p = 64'd1 << (64 - i);
      sum = 0;
      k = 0;
      while (p != 0) begin
         if (k % 2 == 0) begin
            sum = sum + p / (2 * k + 1);
         end else begin
            sum = sum - p / (2 * k + 1);
         end
         p = (2 * i >= 64) ? 64'd0 : (p >> (2 * i));
         k++;
      end
      turns = high_product(sum, 64'h28BE_60DB_9391_054A);
      return longint'((turns + (64'd1 << 31)) >> 32);
   endfunction

   function automatic longint round_mul(input longint a, input longint b);
      return (a * b + (64'sd1 <<< 29)) >>> 30;
   endfunction

   function automatic longint clip_unit(input longint v);
      if (v > 64'sd1073741824) return 64'sd1073741824;
      if (v < -64'sd1073741824) return -64'sd1073741824;
      return v;
   endfunction

   function automatic void sine_cosine(input logic [31:0] ang, output longint s,
                                       output longint c);
      logic [31:0] a;
      bit     flip;
      longint x, y, z, dx, dy;
      a = ang;
      flip = 1'b0;
      // Fold the angle into the CORDIC's convergence range, flipping signs.
      if (a >= eqhz_pkg::AngQuarter && a < eqhz_pkg::AngThreeQuarter) begin
         a = a - eqhz_pkg::AngHalf;
         flip = 1'b1;
      end
      z = longint'($signed(a));
      x = 64'sd652032874;
      y = 0;
      for (int i = 0; i < eqhz_pkg::CordicStages; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - rot_angle[i];
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + rot_angle[i];
         end
      end
      s = flip ? -y : y;
      c = flip ? -x : x;
   endfunction

   function automatic longint vector_angle(input longint y_in, input longint x_in);
      longint x, y, z, t, dx, dy;
      x = x_in;
      y = y_in;
      z = 0;
      if (x < 0) begin
         if (y >= 0) begin
            t = y;
            y = -x;
            x = t;
            z = 64'sd1073741824;
         end else begin
            t = -y;
            y = x;
            x = t;
            z = -64'sd1073741824;
         end
      end
      for (int i = 0; i < eqhz_pkg::CordicStages; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x = x + dx;
            y = y - dy;
            z = z + rot_angle[i];
         end else begin
            x = x - dx;
            y = y + dy;
            z = z - rot_angle[i];
         end
      end
      return z;
   endfunction

   function automatic longint floor_root(input longint unsigned v_in);
      longint unsigned v, r, b;
      v = v_in;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return longint'(r);
   endfunction

   function automatic longint unit_cofactor(input longint s);
      longint unsigned sq, one;
      sq = longint'(s * s);
      one = 64'd1 << 60;
      return floor_root(sq >= one ? 64'd0 : one - sq);
   endfunction

   function automatic horizon_type to_horizon(input logic [31:0] hour_angle,
                                              input logic [31:0] declination);
      horizon_type r;
      longint   sl, cl, sd, cd, sh, ch, s_alt, c_alt, thr, num, den, q, a, z;
      sine_cosine(site_lat, sl, cl);
      sine_cosine(declination, sd, cd);
      sine_cosine(hour_angle, sh, ch);
      thr = longint'({48'd0, near_zero_thr});
      s_alt = clip_unit(round_mul(sl, sd) + round_mul(round_mul(cl, cd), ch));
      c_alt = unit_cofactor(s_alt);
      z = vector_angle(s_alt, c_alt);
      r.altitude = z[31:0];
      r.pole_hit = 1'b0;
      r.edge_hit = 1'b0;
      if ((cl < 0 ? -cl : cl) <= thr) begin
         r.pole_hit = 1'b1;
         r.azimuth = hour_angle;
      end else if (round_mul(round_mul(cd, ch), cl) <= thr &&
                   round_mul(round_mul(cd, ch), cl) >= -thr) begin
         r.edge_hit = 1'b1;
         r.azimuth = (sh >= 0) ? eqhz_pkg::AngQuarter : eqhz_pkg::AngThreeQuarter;
      end else begin
         num = sd - round_mul(s_alt, sl);
         den = round_mul(cl, c_alt);
         // A vanishing divisor saturates the quotient by the numerator's sign.
         if (den == 0) begin
            q = (num > 0) ? 64'sd1073741824 : ((num < 0) ? -64'sd1073741824 : 64'sd0);
         end else begin
            q = clip_unit((num * 64'sd1073741824) / den);
         end
         a = vector_angle(unit_cofactor(q), q);
         if (sh > 0) a = -a;
         r.azimuth = a[31:0];
      end
      return r;
   endfunction

   // ---------------------------------------------------------------- monitors

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         expected_pos.push_back(to_horizon(req_tdata[31:0], req_tdata[63:32]));
      end
   end

   always @(posedge clock) begin
      horizon_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_pos.size() == 0) begin
            report("result beat with nothing expected");
         end else begin
            want = expected_pos.pop_front();
            if (rsp_tdata[31:0] !== want.altitude)
               report($sformatf("altitude %h, expected %h", rsp_tdata[31:0], want.altitude));
            if (rsp_tdata[63:32] !== want.azimuth)
               report($sformatf("azimuth %h, expected %h", rsp_tdata[63:32], want.azimuth));
            if (rsp_tdata[64] !== want.pole_hit)
               report($sformatf("pole flag %b, expected %b", rsp_tdata[64], want.pole_hit));
            if (rsp_tdata[65] !== want.edge_hit)
               report($sformatf("edge flag %b, expected %b", rsp_tdata[65], want.edge_hit));
            if (rsp_tdata[71:66] !== 6'd0)
               report($sformatf("fill bits %b not zero", rsp_tdata[71:66]));
         end
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 95) return $urandom_range(1, 4);
      return $urandom_range(10, 60);
   endfunction

   // Result side: random stalls, plus a long hold-off when a test asks for one.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (hold_request > 0) begin
            stall_left = hold_request;
            hold_request = 0;
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            if (ready_jitter) stall_left = pick_gap();
         end
      end
   end

   // ---------------------------------------------------------------- drivers

   // Entered and left at a falling edge.
   task automatic send_item(input logic [31:0] hour_angle, input logic [31:0] declination);
      int gap;
      gap = sender_jitter ? pick_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {declination, hour_angle};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_pos.size() != 0) @(negedge clock);
      @(negedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx[0], 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (idx == eqhz_pkg::RegLatitude) site_lat = value;
      else near_zero_thr = value[15:0];
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== (idx == eqhz_pkg::RegLatitude ? site_lat : {16'd0, near_zero_thr}))
         report($sformatf("register %0d reads %h", idx, csr_prdata));
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic send_random(input int count);
      logic [31:0] ha, dec;
      for (int n = 0; n < count; n++) begin
         ha = $urandom;
         dec = $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
         case ($urandom_range(0, 5))
            0: dec = $urandom;
            1: ha = {ha[31:30], 30'd0} + $urandom_range(0, 64) - 32;
            2: dec = ($urandom_range(0, 1) ? 32'h4000_0000 : 32'hC000_0000)
                     + $urandom_range(0, 256) - 128;
            3: dec = site_lat + $urandom_range(0, 4096) - 2048;
            default: ;
         endcase
         send_item(ha, dec);
      end
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_directed();
      csr_write(eqhz_pkg::RegLatitude, 32'h0);
      csr_write(eqhz_pkg::RegThreshold, 32'd1);
      send_item(32'h0000_0000, 32'h0000_0000);
      send_item(32'hFFFF_FFFF, 32'h4000_0000);
      send_item(32'h4000_0000, 32'hC000_0000);
      send_item(32'h8000_0000, 32'h7FFF_FFFF);
      send_item(32'hC000_0000, 32'h8000_0000);
      send_item(32'h4000_0000, 32'h1234_5678);
      wait_drained();
      csr_write(eqhz_pkg::RegLatitude, 32'h4000_0000);
      send_item(32'h1357_9BDF, 32'h1000_0000);
      send_item(32'hFFFF_FFFF, 32'hC000_0000);
      wait_drained();
      csr_write(eqhz_pkg::RegLatitude, 32'h2000_0000);
      csr_write(eqhz_pkg::RegThreshold, 32'd0);
      // Zenith: the altitude cosine vanishes and the divisor with it.
      send_item(32'h0000_0000, 32'h2000_0000);
      send_item(32'h8000_0000, 32'hE000_0000);
      send_item(32'h0000_0001, 32'h2000_0001);
      send_item(32'h4000_0000, 32'h0000_0000);
      wait_drained();
      csr_write(eqhz_pkg::RegLatitude, 32'hC000_0000);
      csr_write(eqhz_pkg::RegThreshold, 32'hFFFF);
      send_item(32'h2000_0000, 32'h2000_0000);
      send_item(32'hA5A5_A5A5, 32'h5A5A_5A5A);
      wait_drained();
   endtask

   task automatic test_config_sweep();
      logic [31:0] lats [7] = '{32'h0, 32'h4000_0000, 32'hC000_0000, 32'h3FFF_FF00,
                                32'h8000_0000, 32'h2000_0000, 32'h0};
      logic [15:0] thrs [7] = '{16'd1, 16'd1, 16'd0, 16'hFFFF, 16'd300, 16'd0, 16'hFFFF};
      for (int p = 0; p < 7; p++) begin
         csr_write(eqhz_pkg::RegLatitude, p == 6 ? $urandom : lats[p]);
         csr_write(eqhz_pkg::RegThreshold, {16'd0, p == 6 ? 16'($urandom) : thrs[p]});
         send_random(60);
         wait_drained();
      end
   endtask

   task automatic test_backpressure();
      csr_write(eqhz_pkg::RegLatitude, $urandom_range(0, 32'h8000_0000) - 32'h4000_0000);
      csr_write(eqhz_pkg::RegThreshold, 32'd1);
      sender_jitter = 1'b0;
      @(posedge clock);
      hold_request = 1200;
      @(negedge clock);
      send_random(400);
      sender_jitter = 1'b1;
      wait_drained();
   endtask

   task automatic test_steady_flow();
      ready_jitter = 1'b0;
      sender_jitter = 1'b0;
      send_random(80);
      ready_jitter = 1'b1;
      sender_jitter = 1'b1;
      wait_drained();
   endtask

   initial begin
      for (int i = 0; i < eqhz_pkg::CordicStages; i++) rot_angle[i] = arctan_step(i);
      errors = 0;
      stall_left = 0;
      hold_request = 0;
      sender_jitter = 1'b1;
      ready_jitter = 1'b1;
      site_lat = 32'h0;
      near_zero_thr = 16'd1;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      test_directed();
      test_config_sweep();
      test_backpressure();
      test_steady_flow();

      wait_drained();
      repeat (400) @(posedge clock);
      if (errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("Mismatches found");
      $finish;
   end

endmodule

[filelist.f]
rtl/eqhz_pkg.sv
rtl/equatorial_to_horizontal_top.sv
tb/testbench.sv
